// ----- rtl/sortable_job_queue_unit_macros.svh -----
`ifndef SORTABLE_JOB_QUEUE_UNIT_MACROS_SVH
`define SORTABLE_JOB_QUEUE_UNIT_MACROS_SVH

// same-cycle implication on clk, off during reset
`define SJQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, off during reset
`define SJQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sjq_pkg.sv -----
package sjq_pkg;

	localparam int DEPTH     = 64;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = $clog2(DEPTH + 1);
	localparam int CAP_W     = 7;
	localparam int FILL_W    = 7;
	localparam int START_W   = 31;
	localparam int TAG_W     = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	typedef enum logic [1:0] {
		OP_ENQ,
		OP_DEQ,
		OP_PEEK,
		OP_SORT
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_EMPTY
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_KEY_RD,
		S_KEY_LD,
		S_CMP,
		S_PLACE,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t                opcode;
		logic [START_W-1:0] job_start;
		logic [TAG_W-1:0]   job_tag;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [START_W-1:0] head_start;
		logic [TAG_W-1:0]   head_tag;
		logic [FILL_W-1:0]  fill_level;
		logic               empty_flag;
		logic               full_flag;
	} rsp_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [TAG_W-1:0]   tag;
	} entry_t;

endpackage

// ----- rtl/sortable_job_queue_unit.sv -----
// Sortable job queue.
// Request channel: drive req and pulse start; the request is taken at a
// clock edge with start high and busy low. Opcodes: enqueue at tail,
// dequeue head, peek head, stable sort of held entries by start time.
// Result channel: done is high for exactly one cycle with rsp valid; the
// receiver must take it then, it cannot stall the block.
// Enqueue, dequeue and peek: result in the cycle after the request, while
// busy is high, so the block takes no new request until the result is given.
// Sort of n entries: in-place insertion sort over the entry RAM, one read
// and one write per cycle through a single key comparator.
// Entries live in a circular RAM addressed from a head pointer; dequeue
// only advances the pointer.
// Capacity register: cfg_we with cfg_data, write only while idle; values
// above the RAM depth act as the depth.
// Reset: queue empty, head at 0, capacity 64; RAM contents are not
// cleared and need no clearing pass.
`include "sortable_job_queue_unit_macros.svh"

module sortable_job_queue_unit
	import sjq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam int EW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
		input logic [AW-1:0] ofs);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, ofs};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[AW-1:0];
	endfunction

	entry_t mem [DEPTH];

	state_t           state_q, state_d;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic [CAP_W-1:0] cap_q;
	logic [AW-1:0]    i_q, j_q;
	entry_t           key_q;
	entry_t           rd_data_q;
	status_t          status_q;
	logic             hv_q;

	logic             mem_we;
	logic [AW-1:0]    wr_addr, rd_addr;
	entry_t           wr_data;
	logic             accept, full_now, greater, last_key;
	logic [AW-1:0]    j_m1, j_m2;

	assign accept   = start && !busy;
	assign full_now = (EW'(count_q) >= EW'(cap_q)) || (count_q == CW'(DEPTH));
	assign greater  = rd_data_q.start > key_q.start;
	assign last_key = (CW'(i_q) + CW'(1)) == count_q;
	assign j_m1     = j_q - AW'(1);
	assign j_m2     = j_q - AW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		wr_addr = phys(head_q, j_q);
		wr_data = rd_data_q;
		rd_addr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DONE;
					unique case (req.opcode)
						OP_ENQ: begin
							if (!full_now) begin
								mem_we  = 1'b1;
								wr_addr = phys(head_q, count_q[AW-1:0]);
								wr_data = '{start: req.job_start, tag: req.job_tag};
							end
						end
						OP_DEQ, OP_PEEK: begin
						end
						OP_SORT: begin
							if (count_q > CW'(1)) begin
								state_d = S_KEY_RD;
							end
						end
					endcase
				end
			end
			S_KEY_RD: begin
				rd_addr = phys(head_q, i_q);
				state_d = S_KEY_LD;
			end
			S_KEY_LD: begin
				rd_addr = phys(head_q, j_m1);
				state_d = S_CMP;
			end
			S_CMP: begin
				rd_addr = phys(head_q, j_m2);
				if (greater) begin
					mem_we = 1'b1;
					state_d = (j_q == AW'(1)) ? S_PLACE : S_CMP;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				mem_we  = 1'b1;
				wr_data = key_q;
				state_d = last_key ? S_DONE : S_KEY_RD;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (accept && req.opcode == OP_ENQ && !full_now) begin
				count_q <= count_q + CW'(1);
			end
			if (accept && req.opcode == OP_DEQ && count_q != '0) begin
				count_q <= count_q - CW'(1);
				head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_q <= ST_OK;
					hv_q     <= 1'b0;
					i_q      <= AW'(1);
					unique case (req.opcode)
						OP_ENQ: begin
							if (full_now) begin
								status_q <= ST_FULL;
							end
						end
						OP_DEQ, OP_PEEK: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								hv_q <= 1'b1;
							end
						end
						OP_SORT: begin
						end
					endcase
				end
			end
			S_KEY_RD: j_q <= i_q;
			S_KEY_LD: key_q <= rd_data_q;
			S_CMP: begin
				if (greater) begin
					j_q <= j_m1;
				end
			end
			S_PLACE: i_q <= i_q + AW'(1);
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	always_comb begin
		rsp.status     = status_q;
		rsp.head_start = hv_q ? rd_data_q.start : '0;
		rsp.head_tag   = hv_q ? rd_data_q.tag : '0;
		rsp.fill_level = FILL_W'(count_q);
		rsp.empty_flag = count_q == '0;
		rsp.full_flag  = full_now;
	end

	`SJQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
	`SJQ_ASSERT_NEXT(a_done_idle, done, !busy, "not idle after result")
	`SJQ_ASSERT_NEXT(a_queue_op_one_cycle, accept && req.opcode != OP_SORT, done, "queue op late")
	`SJQ_ASSERT_NEXT(a_deq_count, accept && req.opcode == OP_DEQ && count_q != '0, count_q == $past(count_q) - CW'(1), "dequeue count")

endmodule

// ----- verif/tb_sortable_job_queue_unit.sv -----
module tb_sortable_job_queue_unit;
	import sjq_pkg::*;

	localparam int CYCLE_LIMIT   = 8_000_000;
	localparam int SHOWN_ERRORS  = 10;
	localparam int PHASE_BUDGET  = 88;
	localparam logic [START_W-1:0] START_MAX = '1;
	localparam logic [TAG_W-1:0]   TAG_MAX   = '1;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             rsp;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_data;

	// queue model and results still owed by the block
	entry_t           model_jobs[$];
	logic [CAP_W-1:0] model_capacity = CAP_RESET;
	rsp_t             awaited_results[$];

	bit idle_on = 1'b1;
	int error_count;
	int requests_sent;
	int results_seen;
	int sorts_done;
	int refusals;
	int deepest_fill;
	longint unsigned cycle_count;

	sortable_job_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				awaited_results.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic void report_failure(input string msg);
		error_count++;
		if (error_count <= SHOWN_ERRORS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	function automatic int capacity_limit();
		return (int'(model_capacity) > DEPTH) ? DEPTH : int'(model_capacity);
	endfunction

	// applies one request to the model and returns the response it must give
	function automatic rsp_t apply_queue_op(input req_t r);
		rsp_t   res;
		entry_t key;
		int     lim;
		int     j;
		lim = capacity_limit();
		res = '0;
		res.status = ST_OK;
		case (r.opcode)
			OP_ENQ: begin
				if (model_jobs.size() >= lim || model_jobs.size() >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					key.start = r.job_start;
					key.tag   = r.job_tag;
					model_jobs.push_back(key);
				end
			end
			OP_DEQ, OP_PEEK: begin
				if (model_jobs.size() == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.head_start = model_jobs[0].start;
					res.head_tag   = model_jobs[0].tag;
					if (r.opcode == OP_DEQ)
						void'(model_jobs.pop_front());
				end
			end
			default: begin
				// stable insertion sort on start time
				for (int i = 1; i < model_jobs.size(); i++) begin
					key = model_jobs[i];
					j = i;
					while (j > 0 && model_jobs[j-1].start > key.start) begin
						model_jobs[j] = model_jobs[j-1];
						j--;
					end
					model_jobs[j] = key;
				end
				sorts_done++;
			end
		endcase
		if (res.status != ST_OK)
			refusals++;
		if (model_jobs.size() > deepest_fill)
			deepest_fill = model_jobs.size();
		res.fill_level = FILL_W'(model_jobs.size());
		res.empty_flag = (model_jobs.size() == 0);
		res.full_flag  = (model_jobs.size() >= lim);
		return res;
	endfunction

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				report_failure($sformatf("unexpected result st=%0d fill=%0d",
					rsp.status, rsp.fill_level));
			end else begin
				want = awaited_results.pop_front();
				if (rsp.status !== want.status || rsp.head_start !== want.head_start ||
					rsp.head_tag !== want.head_tag || rsp.fill_level !== want.fill_level ||
					rsp.empty_flag !== want.empty_flag || rsp.full_flag !== want.full_flag) begin
					report_failure($sformatf(
						"exp st=%0d hs=%h ht=%h fill=%0d e=%b f=%b / got st=%0d hs=%h ht=%h fill=%0d e=%b f=%b",
						want.status, want.head_start, want.head_tag, want.fill_level,
						want.empty_flag, want.full_flag, rsp.status, rsp.head_start,
						rsp.head_tag, rsp.fill_level, rsp.empty_flag, rsp.full_flag));
				end
			end
		end
	end

	function automatic req_t make_req(input op_t op, input logic [START_W-1:0] s,
		input logic [TAG_W-1:0] t);
		req_t r;
		r.opcode    = op;
		r.job_start = s;
		r.job_tag   = t;
		return r;
	endfunction

	function automatic req_t random_request(input op_t op);
		logic [START_W-1:0] s;
		case ($urandom_range(0, 9))
			0:       s = '0;
			1:       s = START_MAX;
			2, 3, 4: s = START_W'($urandom_range(0, 7));
			default: s = START_W'($urandom);
		endcase
		return make_req(op, s, TAG_W'($urandom));
	endfunction

	// drives one request and returns at the edge where it is taken
	task automatic send_request(input req_t r);
		if (idle_on && $urandom_range(0, 99) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
		awaited_results.push_back(apply_queue_op(r));
		requests_sent++;
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		start <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_capacity = value;
	endtask

	task automatic test_empty_queue();
		send_request(make_req(OP_DEQ, START_MAX, TAG_MAX));
		send_request(make_req(OP_PEEK, '0, '0));
		send_request(make_req(OP_SORT, START_MAX, TAG_MAX));
	endtask

	task automatic test_order_and_extremes();
		send_request(make_req(OP_ENQ, START_MAX, TAG_MAX));
		send_request(make_req(OP_SORT, '0, '0));
		send_request(make_req(OP_ENQ, '0, '0));
		send_request(make_req(OP_SORT, '0, '0));
		send_request(make_req(OP_PEEK, START_MAX, TAG_MAX));
		send_request(make_req(OP_DEQ, '0, '0));
		send_request(make_req(OP_DEQ, '0, '0));
	endtask

	task automatic test_stable_sort();
		send_request(make_req(OP_ENQ, 31'd5, 32'hA000_0001));
		send_request(make_req(OP_ENQ, 31'd3, 32'hB000_0002));
		send_request(make_req(OP_ENQ, 31'd5, 32'hC000_0003));
		send_request(make_req(OP_SORT, '0, '0));
		repeat (3) send_request(make_req(OP_DEQ, '0, '0));
	endtask

	task automatic test_capacity_limits();
		write_capacity(CAP_W'(2));
		send_request(make_req(OP_ENQ, 31'd9, 32'h0000_0009));
		send_request(make_req(OP_ENQ, 31'd1, 32'h0000_0001));
		send_request(make_req(OP_ENQ, 31'd4, 32'h0000_0004));
		// shrink below the current fill
		write_capacity(CAP_W'(1));
		send_request(make_req(OP_ENQ, 31'd4, 32'h0000_0004));
		send_request(make_req(OP_DEQ, '0, '0));
		write_capacity(CAP_W'(0));
		send_request(make_req(OP_DEQ, '0, '0));
		send_request(make_req(OP_ENQ, 31'd2, 32'h0000_0002));
		write_capacity(CAP_W'(127));
		send_request(make_req(OP_ENQ, 31'd7, 32'h5555_AAAA));
		send_request(make_req(OP_DEQ, '0, '0));
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0] caps[8] = '{7'd64, 7'd3, 7'd127, 7'd0, 7'd1, 7'd64, 7'd20, 7'd100};
		int budget;
		int n;
		op_t op;
		for (int p = 0; p < 8; p++) begin
			write_capacity(caps[p]);
			idle_on = (p != 5);
			budget = PHASE_BUDGET;
			while (budget > 0) begin
				case ($urandom_range(0, 2))
					0: n = ((capacity_limit() > model_jobs.size()) ?
						capacity_limit() - model_jobs.size() : 0) + $urandom_range(1, 3);
					1: n = model_jobs.size() + $urandom_range(1, 2);
					default: n = $urandom_range(5, 25);
				endcase
				op = OP_SORT;
				for (int k = 0; k < n && budget > 0; k++) begin
					if (n == 0) break;
					case ($urandom_range(0, 2))
						default: op = op_t'($urandom_range(0, 3));
					endcase
					if (n > 25 || (k == 0 && op == OP_SORT)) begin
						// burst aimed at filling
						op = (model_jobs.size() < capacity_limit() && $urandom_range(0, 99) < 88) ?
							OP_ENQ : op;
					end
					send_request(random_request(op));
					budget--;
				end
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		req      = '0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_order_and_extremes();
		test_stable_sort();
		test_capacity_limits();
		test_random_traffic();

		start <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d requests, %0d results checked, %0d sorts, %0d refused, deepest fill %0d",
			requests_sent, results_seen, sorts_done, refusals, deepest_fill);
		$display("capacities swept from 0 to 127, %0d mismatches", error_count);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
